// ===== sv/demc_pkg.sv =====
// ----------------------------------------------------------------------------
// demc_pkg: shared types and constants for the multi-turn combiner
// Field widths, register indexes, reset values and the divider step function.
// ----------------------------------------------------------------------------
package demc_pkg;

   // field widths
   localparam int ANGLE_W = 12;
   localparam int POS_W   = 25;
   localparam int CSR_IDX_W = 3;

   // register indexes on the csr port
   localparam logic [CSR_IDX_W-1:0] CSR_REDUCTION_ZERO = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FAST_ZERO      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_SPAN      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_WRAP_THRESHOLD = 3'd3;

   // register reset values
   localparam logic [ANGLE_W-1:0] RST_REDUCTION_ZERO = 12'd0;
   localparam logic [ANGLE_W-1:0] RST_FAST_ZERO      = 12'd0;
   localparam logic [ANGLE_W-1:0] RST_STEP_SPAN      = 12'd1024;
   localparam logic [ANGLE_W-1:0] RST_WRAP_THRESHOLD = 12'd4095;

   // fast reading window edges
   localparam logic [ANGLE_W-1:0] WIN_LOW  = 12'd1024;
   localparam logic [ANGLE_W-1:0] WIN_HIGH = 12'd3072;

   // divider: quotient bits resolved per pipeline stage
   localparam int DIV_BITS   = 3;
   localparam int DIV_STAGES = ANGLE_W / DIV_BITS;

   // item state carried down the pipeline
   typedef struct packed {
      logic [ANGLE_W-1:0] num;     // dividend bits still to be consumed
      logic [ANGLE_W-1:0] rem;     // partial remainder
      logic [ANGLE_W-1:0] quo;     // quotient bits so far
      logic [ANGLE_W-1:0] f;       // fast offset
      logic [ANGLE_W-1:0] fraw;    // raw fast reading
      logic               r_wrap;  // reduction offset past threshold
      logic               f_wrap;  // fast offset past threshold
   } work_type;

   // resolve DIV_BITS quotient bits of a restoring division
   function automatic work_type div_step(work_type w, logic [ANGLE_W-1:0] span);
      work_type         o;
      logic [ANGLE_W:0] t;
      o = w;
      for (int i = 0; i < DIV_BITS; i++) begin
         t     = {o.rem, o.num[ANGLE_W-1]};
         o.num = {o.num[ANGLE_W-2:0], 1'b0};
         if (t >= {1'b0, span}) begin
            o.rem = ANGLE_W'(t - {1'b0, span});
            o.quo = {o.quo[ANGLE_W-2:0], 1'b1};
         end else begin
            o.rem = t[ANGLE_W-1:0];
            o.quo = {o.quo[ANGLE_W-2:0], 1'b0};
         end
      end
      return o;
   endfunction

endpackage

// ===== sv/dual_encoder_multiturn_combiner_unit.sv =====
// ----------------------------------------------------------------------------
// dual_encoder_multiturn_combiner_unit: dual encoder multi-turn combiner
// Merges a geared reduction reading and a fast reading into one position.
// ----------------------------------------------------------------------------
// Usage
//   req_*  : one item per pair of raw 12-bit readings; accepted on an edge with
//            req_valid high and req_stall low.
//   rsp_*  : one signed 25-bit position per item, in order; taken on an edge
//            with rsp_valid high and rsp_stall low.
//   csr_*  : register writes (index, data); csr_ready is always high. Write
//            only while no item is in flight.
// Pipeline and throughput
//   An accepted item passes through the offset subtraction stage, then four
//   stages of the pipelined restoring divider (3 quotient bits each) and the
//   output stage that picks the turn multiple, before it shows on rsp_valid.
//   One item is taken every cycle while the receiver does not stall.
// Reset and stall
//   reset clears all stage valid bits and loads the register defaults.
//   When the receiver stalls, the result holds and items close up behind it;
//   req_stall rises only once every stage is occupied.
// ----------------------------------------------------------------------------
module dual_encoder_multiturn_combiner_unit
   import demc_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [ANGLE_W-1:0]          req_reduction_raw,
   input  logic [ANGLE_W-1:0]          req_fast_raw,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic signed [POS_W-1:0]     rsp_position,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [CSR_IDX_W-1:0]        csr_index,
   input  logic [ANGLE_W-1:0]          csr_data
);

   localparam int MULT_W = POS_W - 11;
   localparam logic [MULT_W-1:0] MULT_WRAP = -14'sd2;

   logic [ANGLE_W-1:0] reduction_zero_ff, fast_zero_ff, step_span_ff, wrap_threshold_ff;
   logic [ANGLE_W-1:0] span;

   work_type           s1_ff, s1_in;
   logic               s1_v_ff;
   work_type           div_ff [DIV_STAGES];
   work_type           div_in [DIV_STAGES];
   logic [DIV_STAGES-1:0] div_v_ff;
   logic [DIV_STAGES:0]   div_v_chain;
   logic [DIV_STAGES:0]   div_rdy;
   logic               s1_rdy, out_rdy;

   logic [MULT_W-1:0]  mult;
   logic [ANGLE_W-1:0] s_q;
   logic [POS_W-1:0]   position_in;
   logic signed [POS_W-1:0] rsp_position_ff;
   logic               rsp_valid_ff;

   // register writes
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         reduction_zero_ff <= RST_REDUCTION_ZERO;
         fast_zero_ff      <= RST_FAST_ZERO;
         step_span_ff      <= RST_STEP_SPAN;
         wrap_threshold_ff <= RST_WRAP_THRESHOLD;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_REDUCTION_ZERO: reduction_zero_ff <= csr_data;
            CSR_FAST_ZERO:      fast_zero_ff      <= csr_data;
            CSR_STEP_SPAN:      step_span_ff      <= csr_data;
            CSR_WRAP_THRESHOLD: wrap_threshold_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // a zero span divides as one
   assign span = (step_span_ff == '0) ? ANGLE_W'(1) : step_span_ff;

   // advance a stage when it is empty or the one after it moves
   assign out_rdy             = !rsp_valid_ff || !rsp_stall;
   assign div_rdy[DIV_STAGES] = out_rdy;
   for (genvar k = 0; k < DIV_STAGES; k++) begin : g_rdy
      assign div_rdy[k] = !div_v_ff[k] || div_rdy[k+1];
   end
   assign s1_rdy    = !s1_v_ff || div_rdy[0];
   assign req_stall = !s1_rdy;

   // stage 1: remove zero offsets, test thresholds
   always_comb begin
      s1_in.num    = req_reduction_raw - reduction_zero_ff;
      s1_in.f      = req_fast_raw - fast_zero_ff;
      s1_in.rem    = '0;
      s1_in.quo    = '0;
      s1_in.fraw   = req_fast_raw;
      s1_in.r_wrap = s1_in.num >= wrap_threshold_ff;
      s1_in.f_wrap = s1_in.f >= wrap_threshold_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else if (s1_rdy) begin
         s1_v_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_rdy && req_valid) begin
         s1_ff <= s1_in;
      end
   end

   // valid bit feeding each divider stage
   assign div_v_chain = {div_v_ff, s1_v_ff};

   // divider stages: DIV_BITS (3) quotient bits each
   for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
      if (k == 0) begin : g_first
         assign div_in[k] = div_step(s1_ff, span);
      end else begin : g_next
         assign div_in[k] = div_step(div_ff[k-1], span);
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            div_v_ff[k] <= 1'b0;
         end else if (div_rdy[k]) begin
            div_v_ff[k] <= div_v_chain[k];
         end
      end

      always_ff @(posedge clock) begin
         if (div_rdy[k]) begin
            div_ff[k] <= div_in[k];
         end
      end
   end

   // pick the turn multiple, in units of half a fast turn
   assign s_q = div_ff[DIV_STAGES-1].quo;

   always_comb begin
      work_type w;
      w = div_ff[DIV_STAGES-1];
      priority if (w.f_wrap) begin
         mult = MULT_WRAP;
      end else if (w.r_wrap) begin
         // first pass tests the raw fast reading
         if (s_q[0]) begin
            mult = (w.fraw >= WIN_LOW) ? MULT_W'(s_q) : MULT_W'(s_q) + MULT_W'(1);
         end else if (w.fraw <= WIN_HIGH) begin
            mult = MULT_W'(s_q);
         end else begin
            mult = (|s_q) ? MULT_W'(s_q) - MULT_W'(1) : MULT_WRAP;
         end
      end else begin
         // second pass tests the fast offset, whole turns only
         if (s_q[0]) begin
            mult = (w.f >= WIN_LOW) ? MULT_W'(s_q) - MULT_W'(1)
                                    : MULT_W'(s_q) + MULT_W'(1);
         end else if (w.f <= WIN_HIGH) begin
            mult = MULT_W'(s_q);
         end else begin
            mult = (|s_q) ? MULT_W'(s_q) - MULT_W'(2) : '0;
         end
      end
      position_in = {mult, 11'b0} + {{(POS_W-ANGLE_W){1'b0}}, w.f};
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_rdy) begin
         rsp_valid_ff <= div_v_ff[DIV_STAGES-1];
      end
   end

   always_ff @(posedge clock) begin
      if (out_rdy) begin
         rsp_position_ff <= position_in;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_position = rsp_position_ff;

endmodule

// ===== sv/demc_checker.sv =====
// ----------------------------------------------------------------------------
// demc_checker: port-level checks for the multi-turn combiner
// Watches the top level's channels and flags slips in flow and range.
// ----------------------------------------------------------------------------
module demc_checker
   import demc_pkg::*;
(
   input logic                    clock,
   input logic                    reset,
   input logic                    req_stall,
   input logic                    rsp_valid,
   input logic                    rsp_stall,
   input logic signed [POS_W-1:0] rsp_position
);

   // drop every result on reset
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   // hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_position)))
      else $error("stalled result changed");

   // push back on the input only when the output is blocked
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("req_stall without a blocked result");

   // keep results at or above -4096, the low end of the combined range
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_position >= -25'sd4096))
      else $error("position below range");

endmodule

bind dual_encoder_multiturn_combiner_unit demc_checker u_demc_checker (
   .clock        (clock),
   .reset        (reset),
   .req_stall    (req_stall),
   .rsp_valid    (rsp_valid),
   .rsp_stall    (rsp_stall),
   .rsp_position (rsp_position)
);
